[src/slms_pkg.sv]
package slms_pkg;

  // Operation codes of an input beat.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_LENGTH   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_PER_STEP = 1'b1;

  // Field and register widths.
  localparam int unsigned ADDRESS_W   = 7;
  localparam int unsigned GLYPH_W     = 8;
  localparam int unsigned COLUMN_W    = 4;
  localparam int unsigned LENGTH_W    = 7;
  localparam int unsigned FRAMES_W    = 5;
  localparam int unsigned CFG_DATA_W  = 7;

  // Reset values of the configuration registers.
  localparam logic [LENGTH_W-1:0] SCROLL_LENGTH_RESET   = 7'd65;
  localparam logic [FRAMES_W-1:0] FRAMES_PER_STEP_RESET = 5'd30;

  typedef struct packed {
    logic                 operation;
    logic [ADDRESS_W-1:0] address;
    logic [GLYPH_W-1:0]   glyph_byte;
  } in_item_t;

  typedef struct packed {
    logic                serial_data;
    logic                shift_pulse;
    logic                latch_pulse;
    logic [GLYPH_W-1:0]  row_pattern;
    logic [COLUMN_W-1:0] column_index;
  } out_item_t;

endpackage

[src/scrolling_led_matrix_scanner.sv]
// An accepted beat passes stage 1 and the output register. Throughput: one
// input beat per cycle while item_stall is low; the message store has one
// write and one registered read port, and a latch tick reads it once.
// Reset: control state and registers return to their reset values, then a
// clearing pass zeroes every entry of the message store while item_stall
// is held high.
module scrolling_led_matrix_scanner #(
  parameter int unsigned MESSAGE_DEPTH = 128,
  parameter int unsigned COLUMNS       = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  slms_pkg::in_item_t                     item,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output slms_pkg::out_item_t                    result,
  input  logic                                   cfg_write,
  input  logic [slms_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [slms_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int unsigned AW   = $clog2(MESSAGE_DEPTH);
  localparam int unsigned CW   = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;
  localparam int unsigned BW   = $clog2(COLUMNS + 1);
  localparam int unsigned XW   =
    ((AW > slms_pkg::ADDRESS_W) ? AW : slms_pkg::ADDRESS_W) + 1;
  localparam int unsigned SW   =
    ((CW > slms_pkg::LENGTH_W) ? CW : slms_pkg::LENGTH_W) + 1;
  localparam int unsigned MW   = (SW > AW) ? SW : AW;
  localparam int unsigned NSUB = ((2 ** SW) - 1) / MESSAGE_DEPTH;

  // Configuration registers.
  logic [slms_pkg::LENGTH_W-1:0] scroll_length;
  logic [slms_pkg::FRAMES_W-1:0] frames_per_step;

  // Scan state.
  logic [slms_pkg::LENGTH_W-1:0] scroll_offset;
  logic [slms_pkg::FRAMES_W-1:0] frame_count;
  logic [CW-1:0]                 column_count;
  logic [BW-1:0]                 bit_slot;
  logic [slms_pkg::GLYPH_W-1:0]  row_register;

  // Message store and its clearing pass.
  logic [slms_pkg::GLYPH_W-1:0] message_store [MESSAGE_DEPTH];
  logic [slms_pkg::GLYPH_W-1:0] rd_data;
  logic                         clr_busy;
  logic [AW-1:0]                clr_addr;

  // Pipeline stage between the store read and the output register.
  logic                s1_valid;
  slms_pkg::out_item_t s1_item;

  logic                          advance;
  logic                          s1_move;
  logic                          accept;
  logic                          is_tick;
  logic                          is_latch;
  logic                          serial_bit;
  logic [BW-1:0]                 target_slot;
  logic [XW-1:0]                 addr_x;
  logic                          addr_ok;
  logic [SW-1:0]                 sum;
  logic [MW-1:0]                 sum_red;
  logic [AW-1:0]                 rd_idx;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [slms_pkg::GLYPH_W-1:0]  mem_wdata;
  logic [CW+slms_pkg::COLUMN_W-1:0] col_ext;
  logic [slms_pkg::FRAMES_W:0]   frame_inc;
  logic [slms_pkg::LENGTH_W:0]   offset_inc;

  // Handshake: the output register frees the stage ahead of it.
  always_comb begin
    advance    = !result_valid || !result_stall;
    s1_move    = s1_valid && advance;
    item_stall = clr_busy || (s1_valid && !advance);
    accept     = item_valid && !item_stall;
  end

  // Decode of the accepted beat.
  always_comb begin
    is_tick     = (item.operation == slms_pkg::OP_TICK);
    is_latch    = is_tick && (bit_slot >= BW'(COLUMNS));
    target_slot = BW'(COLUMNS - 1) - BW'(column_count);
    serial_bit  = is_tick && !is_latch && (bit_slot != target_slot);
    col_ext     = (CW + slms_pkg::COLUMN_W)'(column_count);
    addr_x      = XW'(item.address);
    addr_ok     = (addr_x < XW'(MESSAGE_DEPTH));
    frame_inc   = {1'b0, frame_count} + 1'b1;
    offset_inc  = {1'b0, scroll_offset} + 1'b1;
  end

  // Store read index: offset plus column, folded into the store depth.
  always_comb begin
    sum     = SW'(scroll_offset) + SW'(column_count);
    sum_red = MW'(sum);
    for (int k = 0; k < NSUB; k++) begin
      if (sum_red >= MW'(MESSAGE_DEPTH)) begin
        sum_red = sum_red - MW'(MESSAGE_DEPTH);
      end
    end
    rd_idx = sum_red[AW-1:0];
  end

  // Store write port, shared by the clearing pass and write beats.
  always_comb begin
    mem_we    = clr_busy || (accept && !is_tick && addr_ok);
    mem_waddr = clr_busy ? clr_addr : addr_x[AW-1:0];
    mem_wdata = clr_busy ? '0 : item.glyph_byte;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      message_store[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data <= message_store[rd_idx];
    end
  end

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == AW'(MESSAGE_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_length   <= slms_pkg::SCROLL_LENGTH_RESET;
      frames_per_step <= slms_pkg::FRAMES_PER_STEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        slms_pkg::REG_SCROLL_LENGTH: begin
          scroll_length <= cfg_data[slms_pkg::LENGTH_W-1:0];
        end
        slms_pkg::REG_FRAMES_PER_STEP: begin
          frames_per_step <= cfg_data[slms_pkg::FRAMES_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Scan counters: bit slot, column, frame and scroll offset.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_slot      <= '0;
      column_count  <= '0;
      frame_count   <= '0;
      scroll_offset <= '0;
    end else if (accept && is_tick) begin
      if (!is_latch) begin
        bit_slot <= bit_slot + 1'b1;
      end else begin
        bit_slot <= '0;
        if (column_count != CW'(COLUMNS - 1)) begin
          column_count <= column_count + 1'b1;
        end else begin
          column_count <= '0;
          if (frame_inc < {1'b0, frames_per_step}) begin
            frame_count <= frame_inc[slms_pkg::FRAMES_W-1:0];
          end else begin
            frame_count <= '0;
            if (offset_inc >= {1'b0, scroll_length}) begin
              scroll_offset <= '0;
            end else begin
              scroll_offset <= offset_inc[slms_pkg::LENGTH_W-1:0];
            end
          end
        end
      end
    end
  end

  // Stage 1: holds the beat while the store read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.serial_data  <= serial_bit;
      s1_item.shift_pulse  <= is_tick && !is_latch;
      s1_item.latch_pulse  <= is_latch;
      s1_item.row_pattern  <= '0;
      s1_item.column_index <= col_ext[slms_pkg::COLUMN_W-1:0];
    end
  end

  // Row register takes the store byte when a latch beat leaves stage 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_register <= '0;
    end else if (s1_move && s1_item.latch_pulse) begin
      row_register <= rd_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result.serial_data  <= s1_item.serial_data;
      result.shift_pulse  <= s1_item.shift_pulse;
      result.latch_pulse  <= s1_item.latch_pulse;
      result.row_pattern  <= s1_item.latch_pulse ? rd_data : row_register;
      result.column_index <= s1_item.column_index;
    end
  end

endmodule

[tb/sv/tb_scrolling_led_matrix_scanner.sv]
`timescale 1ns / 1ps

module tb_scrolling_led_matrix_scanner;

  localparam int unsigned MSG_DEPTH = 128;
  localparam int unsigned NUM_COLS  = 16;
  localparam int unsigned NUM_PHASES = 7;
  // Phase in which the sender holds off mid-stream until all results are back.
  localparam int unsigned HOLD_PHASE = 3;
  localparam int unsigned DRAIN_LIMIT = 20000;

  // Clock, reset and block ports.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  slms_pkg::in_item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  slms_pkg::out_item_t result;
  logic cfg_write = 1'b0;
  logic [slms_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [slms_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always #10 clk = ~clk;

  scrolling_led_matrix_scanner #(
    .MESSAGE_DEPTH(MSG_DEPTH),
    .COLUMNS      (NUM_COLS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Scanner state as the testbench sees it.
  logic [slms_pkg::GLYPH_W-1:0] glyph_mem [MSG_DEPTH];
  int unsigned view_offset;
  int unsigned frame_cnt;
  int unsigned col_cnt;
  int unsigned slot_cnt;
  logic [slms_pkg::GLYPH_W-1:0] row_reg;
  int unsigned scroll_len;
  int unsigned frames_per_step;

  // Expected result beats, oldest first.
  slms_pkg::out_item_t pending_results [$];

  // Directed stimulus table.
  typedef struct {
    slms_pkg::in_item_t  beat;
    bit                  typed;
    slms_pkg::out_item_t want;
  } dir_row_t;
  dir_row_t dir_rows [$];

  int unsigned error_count = 0;
  int unsigned result_count = 0;
  int unsigned tick_count = 0;
  int unsigned write_count = 0;
  int unsigned latch_count = 0;
  int unsigned setting_count = 0;
  int unsigned burst_left = 0;

  // Receiver stall pattern state.
  int unsigned stall_pct = 0;
  int unsigned stall_epoch = 0;
  slms_pkg::out_item_t oldest;

  // Works out the result of one beat and moves the scan state along.
  function automatic slms_pkg::out_item_t scan_predict(slms_pkg::in_item_t b);
    slms_pkg::out_item_t r;
    int unsigned shown;
    shown = col_cnt;
    r = '0;
    if (b.operation == slms_pkg::OP_WRITE) begin
      glyph_mem[b.address] = b.glyph_byte;
    end else if (slot_cnt < NUM_COLS) begin
      // The select word has its single low bit at the mirrored column position.
      r.serial_data = (slot_cnt == NUM_COLS - 1 - col_cnt) ? 1'b0 : 1'b1;
      r.shift_pulse = 1'b1;
      slot_cnt++;
    end else begin
      row_reg = glyph_mem[(view_offset + col_cnt) % MSG_DEPTH];
      r.latch_pulse = 1'b1;
      slot_cnt = 0;
      col_cnt++;
      if (col_cnt == NUM_COLS) begin
        col_cnt = 0;
        frame_cnt++;
        // A frame count of zero steps on every frame, same as one.
        if (frame_cnt >= frames_per_step) begin
          frame_cnt = 0;
          view_offset++;
          if (view_offset >= scroll_len) begin
            view_offset = 0;
          end
        end
      end
    end
    r.row_pattern = row_reg;
    r.column_index = slms_pkg::COLUMN_W'(shown);
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    error_count++;
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             result_count, what, got, want);
  endtask

  task automatic add_row(logic op, logic [slms_pkg::ADDRESS_W-1:0] addr,
                         logic [slms_pkg::GLYPH_W-1:0] glyph,
                         bit typed, slms_pkg::out_item_t want);
    dir_row_t r;
    r.beat.operation = op;
    r.beat.address = addr;
    r.beat.glyph_byte = glyph;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  function automatic slms_pkg::in_item_t random_beat(int unsigned tick_pct);
    slms_pkg::in_item_t b;
    b.operation = ($urandom_range(0, 99) < tick_pct) ? slms_pkg::OP_TICK
                                                     : slms_pkg::OP_WRITE;
    b.address = slms_pkg::ADDRESS_W'($urandom_range(0, MSG_DEPTH - 1));
    b.glyph_byte = slms_pkg::GLYPH_W'($urandom_range(0, 255));
    return b;
  endfunction

  // Sends one beat in bursts with random gaps and records what should come back.
  task automatic issue_beat(slms_pkg::in_item_t b, bit typed,
                            slms_pkg::out_item_t want);
    int unsigned gap;
    slms_pkg::out_item_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    item <= b;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = scan_predict(b);
    pending_results.push_back(typed ? want : predicted);
    burst_left--;
    if (b.operation == slms_pkg::OP_WRITE) begin
      write_count++;
    end else begin
      tick_count++;
    end
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    item_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // One register write, with the write port idle again before the task returns.
  task automatic write_register(logic [slms_pkg::CFG_INDEX_W-1:0] idx,
                                int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= slms_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == slms_pkg::REG_SCROLL_LENGTH) begin
      scroll_len = value & 32'h7F;
    end else begin
      frames_per_step = value & 32'h1F;
    end
    setting_count++;
  endtask

  // Receiver: checks each accepted result beat and stalls on its own pattern.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      result_count++;
      if (result.latch_pulse) begin
        latch_count++;
      end
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", result, 0);
      end else begin
        oldest = pending_results.pop_front();
        if (result.serial_data !== oldest.serial_data) begin
          report_mismatch("serial_data", result.serial_data, oldest.serial_data);
        end
        if (result.shift_pulse !== oldest.shift_pulse) begin
          report_mismatch("shift_pulse", result.shift_pulse, oldest.shift_pulse);
        end
        if (result.latch_pulse !== oldest.latch_pulse) begin
          report_mismatch("latch_pulse", result.latch_pulse, oldest.latch_pulse);
        end
        if (result.row_pattern !== oldest.row_pattern) begin
          report_mismatch("row_pattern", result.row_pattern, oldest.row_pattern);
        end
        if (result.column_index !== oldest.column_index) begin
          report_mismatch("column_index", result.column_index, oldest.column_index);
        end
      end
    end
    // Stall density changes from one stretch to the next, zero included.
    if (stall_epoch == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 10;
        2: stall_pct = 50;
        default: stall_pct = 75;
      endcase
      stall_epoch = $urandom_range(20, 300);
    end else begin
      stall_epoch--;
    end
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #(64'd60_000_000);
    $display("run timed out");
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus.
  initial begin
    int unsigned p;
    int unsigned n;
    int unsigned r;
    int unsigned phase_len [NUM_PHASES];
    int unsigned phase_fps [NUM_PHASES];
    int unsigned phase_count [NUM_PHASES];
    int unsigned phase_tick [NUM_PHASES];

    // Phase 0 runs on reset values; later phases cover a one-position scroll,
    // zero settings, a short scroll stepping every frame, the widest frame
    // setting and a full 7-bit scroll length.
    phase_len   = '{65, 1, 0, 3, 112, 127, 2};
    phase_fps   = '{30, 1, 0, 0, 31, 0, 2};
    phase_count = '{150, 100, 100, 650, 100, 580, 150};
    phase_tick  = '{85, 85, 90, 88, 85, 97, 80};

    for (int unsigned a = 0; a < MSG_DEPTH; a++) begin
      glyph_mem[a] = '0;
    end
    view_offset = 0;
    frame_cnt = 0;
    col_cnt = 0;
    slot_cnt = 0;
    row_reg = '0;
    scroll_len = slms_pkg::SCROLL_LENGTH_RESET;
    frames_per_step = slms_pkg::FRAMES_PER_STEP_RESET;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: store extremes, the first column scanned out and latched.
    add_row(slms_pkg::OP_WRITE, 7'd0, 8'hFF, 1, '{1'b0, 1'b0, 1'b0, 8'h00, 4'd0});
    add_row(slms_pkg::OP_WRITE, 7'd127, 8'h80, 1, '{1'b0, 1'b0, 1'b0, 8'h00, 4'd0});
    add_row(slms_pkg::OP_WRITE, 7'd1, 8'h00, 0, '0);
    add_row(slms_pkg::OP_WRITE, 7'd2, 8'h5A, 0, '0);
    add_row(slms_pkg::OP_TICK, 7'd127, 8'hFF, 1, '{1'b1, 1'b1, 1'b0, 8'h00, 4'd0});
    for (r = 1; r < NUM_COLS - 1; r++) begin
      add_row(slms_pkg::OP_TICK, 7'(r), 8'(r), 0, '0);
    end
    // Last shift of column zero carries its low select bit.
    add_row(slms_pkg::OP_TICK, 7'd0, 8'h00, 1, '{1'b0, 1'b1, 1'b0, 8'h00, 4'd0});
    // Latch tick shows entry zero and drives serial data low.
    add_row(slms_pkg::OP_TICK, 7'd0, 8'h00, 1, '{1'b0, 1'b0, 1'b1, 8'hFF, 4'd0});
    add_row(slms_pkg::OP_WRITE, 7'd3, 8'hC3, 1, '{1'b0, 1'b0, 1'b0, 8'hFF, 4'd1});
    add_row(slms_pkg::OP_TICK, 7'd0, 8'h00, 1, '{1'b1, 1'b1, 1'b0, 8'hFF, 4'd1});

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) begin
        foreach (dir_rows[i]) begin
          issue_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
        end
      end else begin
        drain_results();
        write_register(slms_pkg::REG_SCROLL_LENGTH, phase_len[p]);
        write_register(slms_pkg::REG_FRAMES_PER_STEP, phase_fps[p]);
      end
      for (n = 0; n < phase_count[p]; n++) begin
        if (p == HOLD_PHASE && n == phase_count[p] / 2) begin
          drain_results();
        end
        issue_beat(random_beat(phase_tick[p]), 0, '0);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results never delivered", 0, pending_results.size());
    end

    $display("Scanned %0d ticks and %0d store writes, %0d latches checked,",
             tick_count, write_count, latch_count);
    $display("over %0d register writes including zero and full-width settings.",
             setting_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
src/slms_pkg.sv
src/scrolling_led_matrix_scanner.sv
tb/sv/tb_scrolling_led_matrix_scanner.sv
